### rtl/core/hsbc_pkg.sv
// Package for the heap sort by count block: sizes, pair type, controller/datapath links.
package hsbc_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ID_W        = 32;
    localparam int KEY_W       = 20;
    localparam int PAIR_W      = ID_W + KEY_W;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W       = IDX_W + 2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] count;
    } pair_t;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic load;
        logic init_build;
        logic init_extract;
        logic extract;
        logic fetch;
        logic take;
        logic sift_rd;
        logic sift_cmp;
        logic out_rd;
        logic out_ld;
        logic out_next;
        logic clear_set;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic k_zero;
        logic sift_done;
        logic out_last;
    } status_t;

endpackage

### rtl/core/hsbc_if.sv
// Channel interfaces: input pairs and sorted results.
interface hsbc_in_if;
    logic                         valid;
    logic                         ready;
    logic [hsbc_pkg::ID_W-1:0]    user_id;
    logic [hsbc_pkg::KEY_W-1:0]   follower_count;
    logic                         last_entry;

    modport source (output valid, user_id, follower_count, last_entry, input ready);
    modport sink (input valid, user_id, follower_count, last_entry, output ready);
endinterface

interface hsbc_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsbc_pkg::ID_W-1:0]    sorted_id;
    logic [hsbc_pkg::KEY_W-1:0]   sorted_count;
    logic                         last_result;
    logic                         overflow;

    modport source (output valid, sorted_id, sorted_count, last_result, overflow, input ready);
    modport sink (input valid, sorted_id, sorted_count, last_result, overflow, output ready);
endinterface

### rtl/core/hsbc_ram.sv
// Generic RAM: one write port, two registered read ports.
module hsbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/core/hsbc_dp.sv
// Datapath: pair store, heap indexes, sift compare and output register.
module hsbc_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hsbc_pkg::cmd_t              cmd,
    output hsbc_pkg::status_t           status,
    input  logic [hsbc_pkg::ID_W-1:0]   user_id,
    input  logic [hsbc_pkg::KEY_W-1:0]  follower_count,
    output logic [hsbc_pkg::ID_W-1:0]   sorted_id,
    output logic [hsbc_pkg::KEY_W-1:0]  sorted_count,
    output logic                        last_result,
    output logic                        overflow
);
    import hsbc_pkg::*;

    logic [CNT_W-1:0] entries_reg, entries_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] node_reg, node_next;
    pair_t            cur_reg, cur_next;
    logic [CNT_W-1:0] out_idx_reg, out_idx_next;
    pair_t            out_pair_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    pair_t            wdata;
    logic [IDX_W-1:0] raddr_a, raddr_b;
    logic [PAIR_W-1:0] rdata_a, rdata_b;
    pair_t            child_l, child_r;

    logic             full;
    logic [CNT_W-1:0] km1;
    logic [EXT_W-1:0] lc, rc, len_ext;
    logic             gt_l, gt_r, sift_done;
    logic [KEY_W-1:0] best_cnt;
    logic [IDX_W-1:0] pick_idx;
    pair_t            pick_pair;

    hsbc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign child_l = pair_t'(rdata_a);
    assign child_r = pair_t'(rdata_b);

    assign full    = (entries_reg == MAX_CNT);
    assign km1     = k_reg - CNT_W'(1);
    assign lc      = {1'b0, node_reg, 1'b1};
    assign rc      = lc + EXT_W'(1);
    assign len_ext = EXT_W'(len_reg);

    // Left child first, strict greater-than on both tests.
    assign gt_l      = (lc < len_ext) && (child_l.count > cur_reg.count);
    assign best_cnt  = gt_l ? child_l.count : cur_reg.count;
    assign gt_r      = (rc < len_ext) && (child_r.count > best_cnt);
    assign sift_done = !gt_l && !gt_r;
    assign pick_idx  = gt_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    assign pick_pair = gt_r ? child_r : child_l;

    assign status.n_small   = (entries_reg <= CNT_W'(1));
    assign status.k_zero    = (k_reg == '0);
    assign status.sift_done = sift_done;
    assign status.out_last  = out_last_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = cur_reg;
        priority if (cmd.load)
        begin
            we    = !full;
            waddr = entries_reg[IDX_W-1:0];
            wdata = '{id: user_id, count: follower_count};
        end
        else if (cmd.take && cmd.extract)
        begin
            // root goes to the end of the shrinking heap
            we    = 1'b1;
            waddr = k_reg[IDX_W-1:0];
            wdata = child_l;
        end
        else if (cmd.sift_cmp)
        begin
            we    = 1'b1;
            waddr = node_reg;
            wdata = sift_done ? cur_reg : pick_pair;
        end
        else
        begin
            we    = 1'b0;
            waddr = '0;
            wdata = cur_reg;
        end
    end

    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        priority if (cmd.fetch)
        begin
            raddr_a = cmd.extract ? '0 : km1[IDX_W-1:0];
            raddr_b = k_reg[IDX_W-1:0];
        end
        else if (cmd.sift_rd)
        begin
            raddr_a = lc[IDX_W-1:0];
            raddr_b = rc[IDX_W-1:0];
        end
        else if (cmd.out_rd)
        begin
            raddr_a = out_idx_reg[IDX_W-1:0];
        end
        else
        begin
            raddr_a = '0;
            raddr_b = '0;
        end
    end

    always_comb
    begin
        entries_next = entries_reg;
        dropped_next = dropped_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        node_next    = node_reg;
        cur_next     = cur_reg;
        out_idx_next = out_idx_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                entries_next = entries_reg + CNT_W'(1);
            end
        end
        if (cmd.init_build)
        begin
            k_next = entries_reg >> 1;
        end
        if (cmd.init_extract)
        begin
            k_next = entries_reg - CNT_W'(1);
        end
        if (cmd.take)
        begin
            k_next    = km1;
            node_next = cmd.extract ? '0 : km1[IDX_W-1:0];
            len_next  = cmd.extract ? k_reg : entries_reg;
            cur_next  = cmd.extract ? child_r : child_l;
        end
        if (cmd.sift_cmp && !sift_done)
        begin
            node_next = pick_idx;
        end
        if (cmd.out_next)
        begin
            out_idx_next = out_idx_reg + CNT_W'(1);
        end
        if (cmd.clear_set)
        begin
            entries_next = '0;
            dropped_next = 1'b0;
            out_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            dropped_reg <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            entries_reg <= entries_next;
            dropped_reg <= dropped_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        len_reg  <= len_next;
        node_reg <= node_next;
        cur_reg  <= cur_next;
        if (cmd.out_ld)
        begin
            out_pair_reg <= child_l;
            out_last_reg <= (out_idx_reg == entries_reg - CNT_W'(1));
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign sorted_id    = out_pair_reg.id;
    assign sorted_count = out_pair_reg.count;
    assign last_result  = out_last_reg;
    assign overflow     = out_ovf_reg;

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg <= MAX_CNT)
        else $error("store fill count beyond capacity");

    a_clear_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_set |=> (entries_reg == '0) && !dropped_reg && (out_idx_reg == '0))
        else $error("set not cleared after final result");

    a_sift_deeper: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sift_cmp && !sift_done) |=> (node_reg > $past(node_reg)))
        else $error("sift step did not descend");

endmodule

### rtl/core/hsbc_ctrl.sv
// Controller: load, heap build, extract and emit sequencing.
module hsbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  logic              out_ready,
    input  hsbc_pkg::status_t status,
    output hsbc_pkg::cmd_t    cmd
);
    import hsbc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_START    = 9'b000000010,
        ST_FETCH    = 9'b000000100,
        ST_TAKE     = 9'b000001000,
        ST_SIFT_RD  = 9'b000010000,
        ST_SIFT_CMP = 9'b000100000,
        ST_OUT_RD   = 9'b001000000,
        ST_OUT_LD   = 9'b010000000,
        ST_OUT_WAIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   extract_reg, extract_next;

    always_comb
    begin
        state_next   = state_reg;
        extract_next = extract_reg;
        cmd          = '0;
        cmd.extract  = extract_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.n_small)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    cmd.init_build = 1'b1;
                    extract_next   = 1'b0;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd.sift_rd = 1'b1;
                state_next  = ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd.sift_cmp = 1'b1;
                priority if (!status.sift_done)
                begin
                    state_next = ST_SIFT_RD;
                end
                else if (!status.k_zero)
                begin
                    state_next = ST_FETCH;
                end
                else if (!extract_reg)
                begin
                    // heap built: start pulling roots off the end
                    cmd.init_extract = 1'b1;
                    extract_next     = 1'b1;
                    state_next       = ST_FETCH;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd.out_ld = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                cmd.out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_last) |=> (state_reg == ST_START))
        else $error("last transaction did not start the sort");

    a_extract_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(extract_reg) |-> ($past(state_reg) == ST_SIFT_CMP && $past(status.k_zero)))
        else $error("extract phase entered before heap build finished");

endmodule

### rtl/core/heap_sort_by_count.sv
// Top level: collects (id, count) pairs and emits them sorted by ascending count.
//
//  channel     | dir | payload                                         | transaction
//  ------------+-----+-------------------------------------------------+----------------
//  pair_in     | in  | user_id, follower_count, last_entry             | valid & ready
//  sorted_out  | out | sorted_id, sorted_count, last_result, overflow  | valid & ready
//
// Loading accepts each offered pair at once; pair_in is ready only while no set is being sorted
// or emitted. The sort runs on a two-read, one-write store: each sift first fetches and takes
// its start pair, then for each heap level visited reads both children, then compares and writes.
// Results are read, registered, then offered on sorted_out; a stall holds the result register.
// Reset (rst_n, asynchronous) empties the set; store contents need no clearing.
module heap_sort_by_count (
    input  logic            clk,
    input  logic            rst_n,
    hsbc_in_if.sink         pair_in,
    hsbc_out_if.source      sorted_out
);
    import hsbc_pkg::*;

    cmd_t    cmd;
    status_t status;

    hsbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair_in.valid),
        .in_last   (pair_in.last_entry),
        .out_ready (sorted_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hsbc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .user_id        (pair_in.user_id),
        .follower_count (pair_in.follower_count),
        .sorted_id      (sorted_out.sorted_id),
        .sorted_count   (sorted_out.sorted_count),
        .last_result    (sorted_out.last_result),
        .overflow       (sorted_out.overflow)
    );

    assign pair_in.ready    = cmd.in_ready;
    assign sorted_out.valid = cmd.out_valid;

endmodule

### bench/heap_sort_by_count_tb.sv
// Testbench for heap_sort_by_count: directed and random pair sets checked against a heapsort predictor.

typedef struct packed {
    hsbc_pkg::pair_t pair;
    logic            last_result;
    logic            overflow;
} sorted_item_t;

class count_sort_checker;
    hsbc_pkg::pair_t heap[hsbc_pkg::MAX_ENTRIES];
    int              loaded = 0;
    bit              dropped = 1'b0;
    sorted_item_t    awaited[$];
    int              mismatches = 0;

    function void swap_slots(int a, int b);
        hsbc_pkg::pair_t t;
        t       = heap[a];
        heap[a] = heap[b];
        heap[b] = t;
    endfunction

    // Strict greater-than, left child first: keeps tie order of textbook heapsort.
    function void sift_down(int len, int node);
        int top;
        int lc;
        int rc;
        while (node < len)
        begin
            top = node;
            lc  = 2 * node + 1;
            rc  = lc + 1;
            if (lc < len && heap[lc].count > heap[top].count)
                top = lc;
            if (rc < len && heap[rc].count > heap[top].count)
                top = rc;
            if (top == node)
                break;
            swap_slots(node, top);
            node = top;
        end
    endfunction

    function void take_pair(logic [hsbc_pkg::ID_W-1:0] id, logic [hsbc_pkg::KEY_W-1:0] cnt,
                            bit last_entry);
        sorted_item_t item;
        int           k;
        if (loaded < hsbc_pkg::MAX_ENTRIES)
        begin
            heap[loaded].id    = id;
            heap[loaded].count = cnt;
            loaded++;
        end
        else
            dropped = 1'b1;
        if (!last_entry)
            return;
        if (loaded > 1)
        begin
            for (k = loaded / 2; k > 0; k--)
                sift_down(loaded, k - 1);
            for (k = loaded - 1; k > 0; k--)
            begin
                swap_slots(0, k);
                sift_down(k, 0);
            end
        end
        for (k = 0; k < loaded; k++)
        begin
            item.pair        = heap[k];
            item.last_result = (k == loaded - 1);
            item.overflow    = dropped;
            awaited.push_back(item);
        end
        loaded  = 0;
        dropped = 1'b0;
    endfunction

    function void match_result(sorted_item_t got);
        sorted_item_t want;
        if (awaited.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: id=%h count=%h last=%b ovf=%b",
                         got.pair.id, got.pair.count, got.last_result, got.overflow);
            return;
        end
        want = awaited.pop_front();
        if (got.pair.id !== want.pair.id || got.pair.count !== want.pair.count ||
            got.last_result !== want.last_result || got.overflow !== want.overflow)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result differs: expected %h/%h/%b/%b, got %h/%h/%b/%b",
                         want.pair.id, want.pair.count, want.last_result, want.overflow,
                         got.pair.id, got.pair.count, got.last_result, got.overflow);
        end
    endfunction
endclass

module heap_sort_by_count_tb;
    import hsbc_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 50;
    localparam int TOTAL_PAIRS  = 330;

    logic clk;
    logic rst_n;

    hsbc_in_if  pair_in();
    hsbc_out_if sorted_out();

    heap_sort_by_count i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_in    (pair_in),
        .sorted_out (sorted_out)
    );

    count_sort_checker ranks = new();

    int src_calm    = 0;
    int snk_calm    = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int pairs_sent  = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly random gaps, with occasional runs of back-to-back transactions.
    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic send_pair(input logic [ID_W-1:0] id, input logic [KEY_W-1:0] cnt,
                             input bit last_entry);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            pair_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pair_in.valid          <= 1'b1;
        pair_in.user_id        <= id;
        pair_in.follower_count <= cnt;
        pair_in.last_entry     <= last_entry;
        @(posedge clk);
        while (!pair_in.ready)
            @(posedge clk);
        ranks.take_pair(id, cnt, last_entry);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic send_set(input int len);
        int                 mode;
        int                 i;
        logic [KEY_W-1:0]   cnt;
        mode = $urandom_range(0, 2);
        for (i = 0; i < len; i++)
        begin
            case (mode)
                0: cnt = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
                1: cnt = KEY_W'($urandom_range(0, 7));
                default:
                    case ($urandom_range(0, 3))
                        0: cnt = '0;
                        1: cnt = '1;
                        default: cnt = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
                    endcase
            endcase
            send_pair($urandom, cnt, i == len - 1);
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] falling[5];
        int               i;
        int               pick;
        int               len;
        falling = '{20'hFFFFF, 20'h01000, 20'h00300, 20'h00002, 20'h00000};
        rst_n                  <= 1'b0;
        pair_in.valid          <= 1'b0;
        pair_in.user_id        <= '0;
        pair_in.follower_count <= '0;
        pair_in.last_entry     <= 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-pair sets at both extremes.
        send_pair('1, '1, 1'b1);
        send_pair('0, '0, 1'b1);
        // All counts equal.
        for (i = 0; i < 3; i++)
            send_pair(32'h100 + i, 20'd5, i == 2);
        for (i = 0; i < 5; i++)
            send_pair(32'h200 + i, falling[i], i == 4);
        for (i = 0; i < 6; i++)
            send_pair(32'h300 + i, 20'(i * 3), i == 5);
        // Interleaved duplicates.
        for (i = 0; i < 4; i++)
            send_pair(32'h400 + i, (i % 2) ? 20'd3 : 20'd7, i == 3);

        // Exactly full, then full with the last pairs dropped.
        send_set(MAX_ENTRIES);
        send_set(MAX_ENTRIES + 3);
        while (pairs_sent < TOTAL_PAIRS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = MAX_ENTRIES + $urandom_range(1, 4);
            else if (pick == 1)
                len = $urandom_range(40, MAX_ENTRIES);
            else
                len = $urandom_range(1, 12);
            if (len > TOTAL_PAIRS - pairs_sent)
                len = TOTAL_PAIRS - pairs_sent;
            send_set(len);
        end
        pair_in.valid <= 1'b0;

        while (ranks.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ranks.mismatches == 0 && ranks.awaited.size() == 0)
            $display("heap_sort_by_count: match");
        else
            $display("heap_sort_by_count: mismatch");
        $finish;
    end

    initial
    begin
        sorted_out.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || hold_left > 0)
            begin
                sorted_out.ready <= 1'b0;
                if (hold_left > 0)
                    hold_left--;
            end
            else
                sorted_out.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_results
        sorted_item_t got;
        if (rst_n && sorted_out.valid && sorted_out.ready)
        begin
            got.pair.id     = sorted_out.sorted_id;
            got.pair.count  = sorted_out.sorted_count;
            got.last_result = sorted_out.last_result;
            got.overflow    = sorted_out.overflow;
            ranks.match_result(got);
            hold_left = draw_gap(snk_calm);
        end
    end

    // End the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pair_in.valid && pair_in.ready) ||
            (sorted_out.valid && sorted_out.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("heap_sort_by_count: mismatch");
                $finish;
            end
        end
    end

endmodule
